// ----- rtl/mmu_pkg.sv -----
// ----------------------------------------------------------------------------
// mmu_pkg
// Shared constants, types and helpers of the matrix multiply unit.
// ----------------------------------------------------------------------------
package mmu_pkg;

   localparam int MAX_DIM     = 8;
   localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int IDX_W       = $clog2(MAX_DIM);
   localparam int DIM_W       = 4;
   localparam int CNT_W       = 8;
   localparam int ELEM_W      = 16;
   localparam int MUL_W       = 2 * ELEM_W;
   localparam int PROD_W      = 35;
   localparam int RSP_FIELD_W = PROD_W + 2 * IDX_W;
   localparam int RSP_DATA_W  = ((RSP_FIELD_W + 7) / 8) * 8;
   localparam int CSR_ADDR_W  = 2;

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] REG_ROWS_A    = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_INNER_LEN = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_COLS_B    = 2'd2;

   localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(MAX_DIM);

   typedef struct packed {
      logic              a_we;
      logic              b_we;
      logic [ADDR_W-1:0] wr_addr;
      logic              rd_en;
      logic [ADDR_W-1:0] a_rd_addr;
      logic [ADDR_W-1:0] b_rd_addr;
      logic              mac_first;
      logic              emit;
      logic [IDX_W-1:0]  row;
      logic [IDX_W-1:0]  col;
      logic              last;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } stat_type;

   // zero is taken as 1, anything above MAX_DIM as MAX_DIM
   function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] r);
      logic [DIM_W-1:0] d;
      if (r == '0)
         d = DIM_W'(1);
      else if (r > DIM_W'(MAX_DIM))
         d = DIM_W'(MAX_DIM);
      else
         d = r;
      return d;
   endfunction

endpackage

// ----- rtl/mmu_ram.sv -----
// ----------------------------------------------------------------------------
// mmu_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module mmu_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                                        clock,
   input  logic                                        we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                            wdata,
   input  logic                                        re,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                            rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- rtl/mmu_ctrl.sv -----
// ----------------------------------------------------------------------------
// mmu_ctrl
// Controller: dimension registers, load counter and the compute sequencer.
// ----------------------------------------------------------------------------
module mmu_ctrl (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             csr_we,
   input  logic [mmu_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  logic [mmu_pkg::DIM_W-1:0]        csr_wdata,
   input  mmu_pkg::stat_type                stat,
   output mmu_pkg::cmd_type                 cmd
);

   localparam logic [2:0] ST_LOAD   = 3'd0;
   localparam logic [2:0] ST_CALC   = 3'd1;
   localparam logic [2:0] ST_DRAIN1 = 3'd2;
   localparam logic [2:0] ST_DRAIN2 = 3'd3;
   localparam logic [2:0] ST_RESULT = 3'd4;

   logic [2:0]                   state_ff, state_in;
   logic [mmu_pkg::DIM_W-1:0]    rows_ff, rows_in;
   logic [mmu_pkg::DIM_W-1:0]    inner_ff, inner_in;
   logic [mmu_pkg::DIM_W-1:0]    cols_ff, cols_in;
   logic [mmu_pkg::CNT_W-1:0]    load_cnt_ff, load_cnt_in;
   logic [mmu_pkg::IDX_W-1:0]    i_ff, i_in;
   logic [mmu_pkg::IDX_W-1:0]    j_ff, j_in;
   logic [mmu_pkg::IDX_W-1:0]    l_ff, l_in;
   logic [mmu_pkg::ADDR_W-1:0]   a_addr_ff, a_addr_in;
   logic [mmu_pkg::ADDR_W-1:0]   b_addr_ff, b_addr_in;
   logic [mmu_pkg::ADDR_W-1:0]   row_base_ff, row_base_in;

   logic [mmu_pkg::DIM_W-1:0]    m_eff, k_eff, n_eff;
   logic [mmu_pkg::CNT_W-1:0]    a_size, b_size, total, b_off, cnt_next;
   logic [mmu_pkg::ADDR_W-1:0]   next_base;
   logic                         last_l, last_i, last_j;

   always_comb begin
      m_eff     = mmu_pkg::eff_dim(rows_ff);
      k_eff     = mmu_pkg::eff_dim(inner_ff);
      n_eff     = mmu_pkg::eff_dim(cols_ff);
      a_size    = mmu_pkg::CNT_W'(m_eff) * mmu_pkg::CNT_W'(k_eff);
      b_size    = mmu_pkg::CNT_W'(k_eff) * mmu_pkg::CNT_W'(n_eff);
      total     = a_size + b_size;
      b_off     = load_cnt_ff - a_size;
      cnt_next  = load_cnt_ff + mmu_pkg::CNT_W'(1);
      next_base = row_base_ff + mmu_pkg::ADDR_W'(k_eff);
      last_l    = ({1'b0, l_ff} == k_eff - mmu_pkg::DIM_W'(1));
      last_i    = ({1'b0, i_ff} == m_eff - mmu_pkg::DIM_W'(1));
      last_j    = ({1'b0, j_ff} == n_eff - mmu_pkg::DIM_W'(1));
   end

   always_comb begin
      state_in    = state_ff;
      rows_in     = rows_ff;
      inner_in    = inner_ff;
      cols_in     = cols_ff;
      load_cnt_in = load_cnt_ff;
      i_in        = i_ff;
      j_in        = j_ff;
      l_in        = l_ff;
      a_addr_in   = a_addr_ff;
      b_addr_in   = b_addr_ff;
      row_base_in = row_base_ff;
      req_ready   = 1'b0;
      cmd         = '0;
      cmd.a_rd_addr = a_addr_ff;
      cmd.b_rd_addr = b_addr_ff;
      cmd.row       = i_ff;
      cmd.col       = j_ff;
      cmd.last      = last_i && last_j;

      unique case (state_ff)
         ST_LOAD: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (load_cnt_ff < a_size) begin
                  cmd.a_we    = 1'b1;
                  cmd.wr_addr = load_cnt_ff[mmu_pkg::ADDR_W-1:0];
               end else begin
                  cmd.b_we    = 1'b1;
                  cmd.wr_addr = b_off[mmu_pkg::ADDR_W-1:0];
               end
               if (cnt_next == total) begin
                  load_cnt_in = '0;
                  i_in        = '0;
                  j_in        = '0;
                  l_in        = '0;
                  a_addr_in   = '0;
                  b_addr_in   = '0;
                  row_base_in = '0;
                  state_in    = ST_CALC;
               end else begin
                  load_cnt_in = cnt_next;
               end
            end
         end
         ST_CALC: begin
            cmd.rd_en     = 1'b1;
            cmd.mac_first = (l_ff == '0);
            if (last_l) begin
               state_in = ST_DRAIN1;
            end else begin
               l_in      = l_ff + mmu_pkg::IDX_W'(1);
               a_addr_in = a_addr_ff + mmu_pkg::ADDR_W'(1);
               b_addr_in = b_addr_ff + mmu_pkg::ADDR_W'(n_eff);
            end
         end
         ST_DRAIN1: begin
            state_in = ST_DRAIN2;
         end
         ST_DRAIN2: begin
            state_in = ST_RESULT;
         end
         ST_RESULT: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               l_in     = '0;
               if (last_i && last_j) begin
                  state_in = ST_LOAD;
               end else if (last_j) begin
                  i_in        = i_ff + mmu_pkg::IDX_W'(1);
                  j_in        = '0;
                  row_base_in = next_base;
                  a_addr_in   = next_base;
                  b_addr_in   = '0;
                  state_in    = ST_CALC;
               end else begin
                  j_in      = j_ff + mmu_pkg::IDX_W'(1);
                  a_addr_in = row_base_ff;
                  b_addr_in = mmu_pkg::ADDR_W'(j_ff) + mmu_pkg::ADDR_W'(1);
                  state_in  = ST_CALC;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase

      // a write to any of the three dimension registers clears the load count
      if (csr_we) begin
         unique case (csr_addr)
            mmu_pkg::REG_ROWS_A: begin
               rows_in     = csr_wdata;
               load_cnt_in = '0;
            end
            mmu_pkg::REG_INNER_LEN: begin
               inner_in    = csr_wdata;
               load_cnt_in = '0;
            end
            mmu_pkg::REG_COLS_B: begin
               cols_in     = csr_wdata;
               load_cnt_in = '0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_LOAD;
         rows_ff     <= mmu_pkg::DIM_RESET;
         inner_ff    <= mmu_pkg::DIM_RESET;
         cols_ff     <= mmu_pkg::DIM_RESET;
         load_cnt_ff <= '0;
         i_ff        <= '0;
         j_ff        <= '0;
         l_ff        <= '0;
         a_addr_ff   <= '0;
         b_addr_ff   <= '0;
         row_base_ff <= '0;
      end else begin
         state_ff    <= state_in;
         rows_ff     <= rows_in;
         inner_ff    <= inner_in;
         cols_ff     <= cols_in;
         load_cnt_ff <= load_cnt_in;
         i_ff        <= i_in;
         j_ff        <= j_in;
         l_ff        <= l_in;
         a_addr_ff   <= a_addr_in;
         b_addr_ff   <= b_addr_in;
         row_base_ff <= row_base_in;
      end
   end

endmodule

// ----- rtl/mmu_datapath.sv -----
// ----------------------------------------------------------------------------
// mmu_datapath
// Element stores, multiply-accumulate pipeline and the result register.
// ----------------------------------------------------------------------------
module mmu_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  mmu_pkg::cmd_type                  cmd,
   input  logic [mmu_pkg::ELEM_W-1:0]        elem,
   output mmu_pkg::stat_type                 stat,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [mmu_pkg::RSP_DATA_W-1:0]    rsp_data,
   output logic                              rsp_last
);

   logic [mmu_pkg::ELEM_W-1:0]        a_rdata, b_rdata;
   logic                              v1_ff, f1_ff, v2_ff, f2_ff;
   logic signed [mmu_pkg::MUL_W-1:0]  mul_ff;
   logic signed [mmu_pkg::PROD_W-1:0] acc_ff, acc_in, mul_ext;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [mmu_pkg::PROD_W-1:0]        rsp_prod_ff;
   logic [mmu_pkg::IDX_W-1:0]         rsp_row_ff, rsp_col_ff;
   logic                              rsp_last_ff;

   mmu_ram #(
      .WIDTH (mmu_pkg::ELEM_W),
      .DEPTH (mmu_pkg::STORE_DEPTH)
   ) u_a_store (
      .clock (clock),
      .we    (cmd.a_we),
      .waddr (cmd.wr_addr),
      .wdata (elem),
      .re    (cmd.rd_en),
      .raddr (cmd.a_rd_addr),
      .rdata (a_rdata)
   );

   mmu_ram #(
      .WIDTH (mmu_pkg::ELEM_W),
      .DEPTH (mmu_pkg::STORE_DEPTH)
   ) u_b_store (
      .clock (clock),
      .we    (cmd.b_we),
      .waddr (cmd.wr_addr),
      .wdata (elem),
      .re    (cmd.rd_en),
      .raddr (cmd.b_rd_addr),
      .rdata (b_rdata)
   );

   // read -> multiply -> accumulate, one stage each
   always_comb begin
      mul_ext = {{(mmu_pkg::PROD_W - mmu_pkg::MUL_W){mul_ff[mmu_pkg::MUL_W-1]}}, mul_ff};
      acc_in  = f2_ff ? mul_ext : acc_ff + mul_ext;
      stat.out_free = !rsp_valid_ff || rsp_ready;
      rsp_valid_in  = cmd.emit ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         v1_ff        <= cmd.rd_en;
         v2_ff        <= v1_ff;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      f1_ff <= cmd.mac_first;
      f2_ff <= f1_ff;
      if (v1_ff) begin
         mul_ff <= $signed(a_rdata) * $signed(b_rdata);
      end
      if (v2_ff) begin
         acc_ff <= acc_in;
      end
      if (cmd.emit) begin
         rsp_prod_ff <= acc_ff;
         rsp_row_ff  <= cmd.row;
         rsp_col_ff  <= cmd.col;
         rsp_last_ff <= cmd.last;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_last  = rsp_last_ff;
   assign rsp_data  = {{(mmu_pkg::RSP_DATA_W - mmu_pkg::RSP_FIELD_W){1'b0}},
                       rsp_col_ff, rsp_row_ff, rsp_prod_ff};

endmodule

// ----- rtl/matrix_multiply_unit.sv -----
// ----------------------------------------------------------------------------
// matrix_multiply_unit
// Fixed point GEMM: C = A * B with Q8.8 elements and exact Q19.16 results.
// ----------------------------------------------------------------------------
// Usage:
//   Program rows_a / inner_len / cols_b (indexes 0..2) on the csr port while
//   idle; any such write restarts the load. Stream A then B, row-major, one
//   Q8.8 element per req beat. The beat that carries the last B element
//   starts the pass; req_tready is low for the whole pass. For each result
//   the sequencer makes one read per cycle from each store into a single
//   multiplier and accumulator, waits in ST_DRAIN1 and ST_DRAIN2 for the
//   pipeline, then hands the sum to the output register in ST_RESULT.
//   A job loads rows_a*inner_len + inner_len*cols_b elements and returns
//   rows_a*cols_b results; 8x8x8 is 128 elements and 64 results.
//   rsp beats come out in row-major order, tlast on the final one. The output
//   register lets the next dot product proceed while a result waits; if it is
//   still held when the next sum is ready, the sequencer waits for rsp_tready.
//   Reset (synchronous) sets all dimensions to 8, empties the output register
//   and clears the load count; the stores are not cleared.
// ----------------------------------------------------------------------------
module matrix_multiply_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [mmu_pkg::ELEM_W-1:0]       req_tdata,   // [15:0] element_value
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [34:0] product_value, [37:35] row_index, [40:38] col_index, rest zero
   output logic [mmu_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                             rsp_tlast,   // last_flag
   input  logic                             csr_we,
   input  logic [mmu_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  logic [mmu_pkg::DIM_W-1:0]        csr_wdata
);

   mmu_pkg::cmd_type  cmd;
   mmu_pkg::stat_type stat;

   mmu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .stat      (stat),
      .cmd       (cmd)
   );

   mmu_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .elem      (req_tdata),
      .stat      (stat),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_data  (rsp_tdata),
      .rsp_last  (rsp_tlast)
   );

   // no input beat is taken while the stores are being read
   a_no_load_in_pass: assert property (@(posedge clock) disable iff (reset)
      cmd.rd_en |-> !req_tready)
      else $error("input accepted during compute pass");

   // a new sum never overwrites a result that is still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |-> !cmd.emit)
      else $error("result register overwritten");

   // once the final result is issued the block is ready for the next job, with the last rsp beat on the output
   a_ready_after_last: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && cmd.last) |=> (req_tready && rsp_tvalid && rsp_tlast))
      else $error("not back to load after last result");

endmodule
